// File: rtl/core/sha1_pkg.sv
// Shared types and constants for the SHA-1 hash engine.
package sha1_pkg;

  localparam int QueueDepth = 4;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_beat_t;

  localparam logic KindData   = 1'b0;
  localparam logic KindFinish = 1'b1;

  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [31:0] InitH0 = 32'h67452301;
  localparam logic [31:0] InitH1 = 32'hEFCDAB89;
  localparam logic [31:0] InitH2 = 32'h98BADCFE;
  localparam logic [31:0] InitH3 = 32'h10325476;
  localparam logic [31:0] InitH4 = 32'hC3D2E1F0;

  function automatic logic [31:0] round_k(input logic [6:0] r);
    logic [31:0] k;
    if (r < 7'd20) begin
      k = 32'h5A827999;
    end else if (r < 7'd40) begin
      k = 32'h6ED9EBA1;
    end else if (r < 7'd60) begin
      k = 32'h8F1BBCDC;
    end else begin
      k = 32'hCA62C1D6;
    end
    return k;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (r < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (r < 7'd40) begin
      f = b ^ c ^ d;
    end else if (r < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

endpackage

// File: rtl/core/sha1_hash_engine.sv
// Top level of the SHA-1 hash engine: input queue and compression back end.
//   channel | signals                   | direction
//   in      | in_valid in_ready in_data | beats of kind and data_byte
//   out     | out_valid out_ready out_data | digest words, index 0 first
// A data beat is written into the block buffer; every 64th byte starts the 80
// rounds, one per cycle, and the chain update. A finish beat pads with zero
// bytes, runs one or two compressions, then emits five beats.
// Reset clears the queue and loads the initial chain value. The queue keeps
// taking beats while the compression loop or a stalled output holds the back end.
module sha1_hash_engine #(
  parameter int QueueDepth = sha1_pkg::QueueDepth
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sha1_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sha1_pkg::out_beat_t out_data
);
  import sha1_pkg::*;

  logic     q_full;
  logic     q_empty;
  logic     q_pop;
  in_beat_t q_data;

  assign in_ready = !q_full;

  sha1_queue #(.Depth(QueueDepth)) u_queue (
    .clk, .rst,
    .push(in_valid), .push_data(in_data), .full(q_full),
    .pop(q_pop), .pop_data(q_data), .empty(q_empty)
  );

  sha1_core u_core (
    .clk, .rst,
    .q_empty, .q_data, .q_pop,
    .out_valid, .out_ready, .out_data
  );

endmodule

// File: rtl/core/sha1_queue.sv
// Short FIFO of input beats between the front and back of the engine.
module sha1_queue #(
  parameter int Depth = sha1_pkg::QueueDepth
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sha1_pkg::in_beat_t push_data,
  output logic              full,
  input  logic              pop,
  output sha1_pkg::in_beat_t pop_data,
  output logic              empty
);
  import sha1_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  in_beat_t        mem [Depth];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [AW:0]     count;

  assign full     = (count == (AW+1)'(Depth));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + AW'(1);
      end
      count <= count + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
    end
  end

endmodule

// File: rtl/core/sha1_core.sv
// Back end: block buffer, padding, one-round-per-cycle compression and digest output.
module sha1_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  sha1_pkg::in_beat_t q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output sha1_pkg::out_beat_t out_data
);
  import sha1_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PAD   = 6'b000010,
    S_ROUND = 6'b000100,
    S_ADD   = 6'b001000,
    S_LEN   = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t       state;
  logic [31:0]  h [5];
  logic [31:0]  w [16];
  logic [5:0]   fill;
  logic [63:0]  bits;
  logic         finishing;
  logic         final_blk;
  logic [6:0]   round;
  logic [31:0]  a, b, c, d, e;
  logic [2:0]   idx;

  logic [31:0]  w_cur;
  logic [31:0]  w_new;
  logic [31:0]  t;
  logic [1:0]   bsel;

  assign bsel  = fill[1:0];
  assign w_new = {w[13] ^ w[8] ^ w[2] ^ w[0]} << 1 | (w[13] ^ w[8] ^ w[2] ^ w[0]) >> 31;
  assign w_cur = (round < 7'd16) ? w[0] : w_new;
  assign t     = {a[26:0], a[31:27]} + round_f(round, b, c, d) + e + w_cur + round_k(round);

  assign q_pop     = (state == S_IDLE) && !q_empty;
  assign out_valid = (state == S_EMIT);
  assign out_data  = '{digest_word: h[idx], word_index: idx, last_word: (idx == 3'd4)};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      bits      <= '0;
      finishing <= 1'b0;
      final_blk <= 1'b0;
      round     <= '0;
      idx       <= '0;
      h[0] <= InitH0; h[1] <= InitH1; h[2] <= InitH2; h[3] <= InitH3; h[4] <= InitH4;
    end else begin
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            if (q_data.kind == KindData) begin
              w[fill[5:2]][8*(3-bsel) +: 8] <= q_data.data_byte;
              bits <= bits + 64'd8;
              fill <= fill + 6'd1;
              if (fill == 6'd63) begin
                state <= S_ROUND;
                round <= '0;
                a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
              end
            end else begin
              w[fill[5:2]][8*(3-bsel) +: 8] <= PadByte;
              fill      <= fill + 6'd1;
              finishing <= 1'b1;
              state     <= (fill == 6'd63) ? S_ROUND : S_PAD;
              final_blk <= 1'b0;
              round     <= '0;
              a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
            end
          end
        end
        S_PAD: begin
          if (fill == 6'd56 && !final_blk && (fill != 6'd0)) begin
            state <= S_LEN;
          end else begin
            w[fill[5:2]][8*(3-bsel) +: 8] <= 8'h00;
            fill <= fill + 6'd1;
            if (fill == 6'd63) begin
              state <= S_ROUND;
              round <= '0;
              a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
            end
          end
        end
        S_LEN: begin
          w[14]     <= bits[63:32];
          w[15]     <= bits[31:0];
          fill      <= '0;
          final_blk <= 1'b1;
          state     <= S_ROUND;
          round     <= '0;
          a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
        end
        S_ROUND: begin
          for (int i = 0; i < 15; i++) begin
            w[i] <= w[i+1];
          end
          w[15] <= w_cur;
          e <= d;
          d <= c;
          c <= {b[1:0], b[31:2]};
          b <= a;
          a <= t;
          round <= round + 7'd1;
          if (round == 7'd79) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          h[0] <= h[0] + a; h[1] <= h[1] + b; h[2] <= h[2] + c;
          h[3] <= h[3] + d; h[4] <= h[4] + e;
          if (final_blk) begin
            state <= S_EMIT;
            idx   <= '0;
          end else if (finishing) begin
            state <= S_PAD;
            fill  <= '0;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            idx <= idx + 3'd1;
            if (idx == 3'd4) begin
              state     <= S_IDLE;
              fill      <= '0;
              bits      <= '0;
              finishing <= 1'b0;
              final_blk <= 1'b0;
              h[0] <= InitH0; h[1] <= InitH1; h[2] <= InitH2;
              h[3] <= InitH3; h[4] <= InitH4;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: bench/sha1_hash_engine_check.sv
// Checker for the SHA-1 hash engine: watches both channels and predicts digests.
module sha1_hash_engine_check (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  sha1_pkg::in_beat_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  sha1_pkg::out_beat_t out_data,
  output int                  fail_count,
  output int                  digests_pending,
  output int                  digests_done
);
  timeunit 1ns;
  timeprecision 1ps;
  import sha1_pkg::*;

  logic [31:0] chain [5];
  logic [7:0]  blk [64];
  int          fill;
  logic [63:0] msg_bits;
  out_beat_t   digest_q [$];

  function automatic logic [31:0] rol(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic compress();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) begin
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    end
    for (int i = 16; i < 80; i++) begin
      w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    end
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d); k = 32'h5A827999;
      end else if (i < 40) begin
        f = b ^ c ^ d; k = 32'h6ED9EBA1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d; k = 32'hCA62C1D6;
      end
      t = rol(a, 5) + f + e + w[i] + k;
      e = d; d = c; c = rol(b, 30); b = a; a = t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
  endtask

  task automatic clear_message();
    chain[0] = InitH0; chain[1] = InitH1; chain[2] = InitH2;
    chain[3] = InitH3; chain[4] = InitH4;
    fill = 0;
    msg_bits = '0;
  endtask

  task automatic absorb(input in_beat_t beat);
    int pos;
    out_beat_t o;
    if (beat.kind == KindData) begin
      blk[fill] = beat.data_byte;
      fill++;
      msg_bits += 64'd8;
      if (fill == 64) begin
        compress();
        fill = 0;
      end
    end else begin
      pos = fill;
      blk[pos++] = PadByte;
      if (pos > 56) begin
        while (pos < 64) blk[pos++] = 8'h00;
        compress();
        pos = 0;
      end
      while (pos < 56) blk[pos++] = 8'h00;
      for (int i = 0; i < 8; i++) blk[56+i] = msg_bits[63-8*i -: 8];
      compress();
      for (int i = 0; i < 5; i++) begin
        o.digest_word = chain[i];
        o.word_index  = 3'(i);
        o.last_word   = (i == 4);
        digest_q.push_back(o);
      end
      clear_message();
    end
  endtask

  assign digests_pending = digest_q.size();

  always @(posedge clk) begin
    out_beat_t exp_beat;
    if (rst) begin
      clear_message();
      fail_count   = 0;
      digests_done = 0;
    end else begin
      if (in_valid && in_ready) begin
        absorb(in_data);
      end
      if (out_valid && out_ready) begin
        if (digest_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("unexpected digest beat %h idx %0d last %b",
                     out_data.digest_word, out_data.word_index, out_data.last_word);
          end
        end else begin
          exp_beat = digest_q.pop_front();
          if (exp_beat.last_word) digests_done++;
          if (out_data.digest_word !== exp_beat.digest_word ||
              out_data.word_index !== exp_beat.word_index ||
              out_data.last_word !== exp_beat.last_word) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("digest mismatch: expected %h/%0d/%b actual %h/%0d/%b",
                       exp_beat.digest_word, exp_beat.word_index, exp_beat.last_word,
                       out_data.digest_word, out_data.word_index, out_data.last_word);
            end
          end
        end
      end
    end
  end
endmodule

// File: bench/sha1_hash_engine_test.sv
// Top of the SHA-1 hash engine bench: clock, reset, stimulus and verdict.
module sha1_hash_engine_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sha1_pkg::*;

  localparam int ItemTarget = 260;
  localparam int QuietAfter = 215;
  localparam int StallLimit = 5000;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_data;
  int        fail_count;
  int        digests_pending;
  int        digests_done;
  int        items_sent;
  int        stall_cycles;
  int        bytes_sent;
  logic      quiet;

  sha1_hash_engine i_dut (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data
  );

  sha1_hash_engine_check i_check (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .fail_count, .digests_pending, .digests_done
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_beat(input logic kind, input logic [7:0] value);
    logic rdy;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{kind: kind, data_byte: value};
    forever begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
      if (rdy) break;
    end
    items_sent++;
    if (kind == KindData) bytes_sent++;
    if (items_sent >= QuietAfter) quiet = 1'b1;
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) send_beat(KindData, 8'($urandom_range(0, 255)));
    send_beat(KindFinish, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(0, 7)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("sha1_hash_engine verification failed");
        $finish;
      end
    end
  end

  initial begin
    int r;
    int len;
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    items_sent = 0;
    bytes_sent = 0;
    quiet      = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_beat(KindFinish, 8'hFF);
    send_beat(KindData, 8'h00);
    send_beat(KindFinish, 8'h00);
    send_beat(KindData, 8'hFF);
    send_beat(KindFinish, 8'hFF);
    send_beat(KindData, 8'h61);
    send_beat(KindData, 8'h62);
    send_beat(KindData, 8'h63);
    send_beat(KindFinish, 8'h00);
    send_beat(KindData, 8'hAA);
    send_beat(KindData, 8'h55);
    send_beat(KindFinish, 8'hA5);
    while (items_sent < ItemTarget) begin
      r = int'($urandom_range(0, 9));
      if (r < 5) len = int'($urandom_range(0, 12));
      else if (r < 8) len = int'($urandom_range(52, 66));
      else if (r == 8) len = int'($urandom_range(118, 130));
      else len = int'($urandom_range(13, 40));
      if (len > ItemTarget - items_sent - 1) len = ItemTarget - items_sent - 1;
      send_message(len);
    end
    in_valid <= 1'b0;
    while (digests_pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("covered %0d beats: %0d bytes over %0d digests",
             items_sent, bytes_sent, digests_done);
    if (fail_count == 0) begin
      $display("sha1_hash_engine verification clean");
    end else begin
      $display("sha1_hash_engine verification failed");
    end
    $finish;
  end
endmodule
